FILE: rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types, opcodes and sequence lengths for the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // Command and tick opcodes; TICK also marks the idle engine
    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_START   = 3'd1,
        OP_STOP    = 3'd2,
        OP_SEND    = 3'd3,
        OP_RECV    = 3'd4,
        OP_ACK     = 3'd5,
        OP_NACK    = 3'd6,
        OP_WAITACK = 3'd7
    } t_opcode;

    localparam int STEP_W = 5;
    localparam int DATA_W = 8;

    // Phase counts per primitive
    localparam logic [STEP_W-1:0] LEN_START = 5'd4;
    localparam logic [STEP_W-1:0] LEN_STOP  = 5'd3;
    localparam logic [STEP_W-1:0] LEN_SEND  = 5'd24;
    localparam logic [STEP_W-1:0] LEN_RECV  = 5'd17;
    localparam logic [STEP_W-1:0] LEN_SHORT = 5'd3;

    // Sub-phase of one transmitted bit: drive SDA, raise SCL, lower SCL
    typedef enum logic [2:0] {
        BIT_DATA = 3'b001,
        BIT_HIGH = 3'b010,
        BIT_LOW  = 3'b100
    } t_bit_phase;

    // One result item
    typedef struct packed {
        logic              scl_out;
        logic              sda_out;
        logic              busy_res;
        logic              done_res;
        logic [DATA_W-1:0] read_data;
        logic              ack_level;
        logic              rejected;
    } t_result;

    function automatic logic [STEP_W-1:0] seq_length(input t_opcode cmd);
        logic [STEP_W-1:0] len;
        case (cmd)
            OP_START: len = LEN_START;
            OP_STOP:  len = LEN_STOP;
            OP_SEND:  len = LEN_SEND;
            OP_RECV:  len = LEN_RECV;
            default:  len = LEN_SHORT;
        endcase
        return len;
    endfunction

endpackage

FILE: rtl/i2cm_seq.sv
// ----------------------------------------------------------------------------
// i2cm_seq
// Sequencer state and single-pass step logic: one pin write per tick.
// ----------------------------------------------------------------------------
module i2cm_seq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic [2:0]                i_opcode,
    input  logic [7:0]                i_write_data,
    input  logic                      i_sda_sensed,
    output i2cm_pkg::t_result         o_result
);

    logic                          r_scl, n_scl;
    logic                          r_sda, n_sda;
    i2cm_pkg::t_opcode             r_cmd, n_cmd;
    logic [i2cm_pkg::STEP_W-1:0]   r_step, n_step;
    logic [i2cm_pkg::DATA_W-1:0]   r_shift, n_shift;
    logic                          r_ack, n_ack;
    i2cm_pkg::t_bit_phase          r_bit, n_bit;

    i2cm_pkg::t_opcode             op;
    logic                          busy;
    logic [i2cm_pkg::STEP_W-1:0]   step_inc;

    assign op       = i2cm_pkg::t_opcode'(i_opcode);
    assign busy     = (r_cmd != i2cm_pkg::OP_TICK);
    assign step_inc = r_step + 5'd1;

    // Compute next state and the result for this request
    always_comb begin
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_cmd   = r_cmd;
        n_step  = r_step;
        n_shift = r_shift;
        n_ack   = r_ack;
        n_bit   = r_bit;
        o_result.done_res  = 1'b0;
        o_result.rejected  = 1'b0;
        o_result.read_data = '0;
        o_result.ack_level = 1'b1;

        if (op != i2cm_pkg::OP_TICK) begin
            if (busy) begin
                o_result.rejected = 1'b1;
            end else begin
                n_cmd  = op;
                n_step = '0;
                n_bit  = i2cm_pkg::BIT_DATA;
                if (op == i2cm_pkg::OP_SEND) begin
                    n_shift = i_write_data;
                end else if (op == i2cm_pkg::OP_RECV) begin
                    n_shift = '0;
                end
            end
        end else if (busy) begin
            case (r_cmd)
                i2cm_pkg::OP_START: begin
                    case (r_step[1:0])
                        2'd0:    n_sda = 1'b1;
                        2'd1:    n_scl = 1'b1;
                        2'd2:    n_sda = 1'b0;
                        default: n_scl = 1'b0;
                    endcase
                end
                i2cm_pkg::OP_STOP: begin
                    case (r_step[1:0])
                        2'd0:    n_sda = 1'b0;
                        2'd1:    n_scl = 1'b1;
                        default: n_sda = 1'b1;
                    endcase
                end
                i2cm_pkg::OP_SEND: begin
                    case (r_bit)
                        i2cm_pkg::BIT_DATA: begin
                            n_sda = r_shift[i2cm_pkg::DATA_W-1];
                            n_bit = i2cm_pkg::BIT_HIGH;
                        end
                        i2cm_pkg::BIT_HIGH: begin
                            n_scl = 1'b1;
                            n_bit = i2cm_pkg::BIT_LOW;
                        end
                        default: begin
                            n_scl   = 1'b0;
                            n_shift = {r_shift[i2cm_pkg::DATA_W-2:0], 1'b0};
                            n_bit   = i2cm_pkg::BIT_DATA;
                        end
                    endcase
                end
                i2cm_pkg::OP_RECV: begin
                    // Release SDA first, then odd phases raise SCL, even ones sample and lower SCL
                    if (r_step == '0) begin
                        n_sda = 1'b1;
                    end else if (r_step[0]) begin
                        n_scl = 1'b1;
                    end else begin
                        n_shift = {r_shift[i2cm_pkg::DATA_W-2:0], i_sda_sensed};
                        n_scl   = 1'b0;
                    end
                end
                default: begin
                    // ack, nack and wait ack share one three-phase pattern
                    case (r_step[1:0])
                        2'd0:    n_sda = (r_cmd != i2cm_pkg::OP_ACK);
                        2'd1:    n_scl = 1'b1;
                        default: begin
                            if (r_cmd == i2cm_pkg::OP_WAITACK) begin
                                n_ack = i_sda_sensed;
                            end
                            n_scl = 1'b0;
                        end
                    endcase
                end
            endcase

            n_step = step_inc;
            if (step_inc >= i2cm_pkg::seq_length(r_cmd)) begin
                o_result.done_res = 1'b1;
                if (r_cmd == i2cm_pkg::OP_RECV) begin
                    o_result.read_data = n_shift;
                end
                if (r_cmd == i2cm_pkg::OP_WAITACK) begin
                    o_result.ack_level = n_ack;
                end
                n_cmd  = i2cm_pkg::OP_TICK;
                n_step = '0;
            end
        end

        o_result.scl_out  = n_scl;
        o_result.sda_out  = n_sda;
        o_result.busy_res = (n_cmd != i2cm_pkg::OP_TICK);
    end

    // Advance the state on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_cmd   <= i2cm_pkg::OP_TICK;
            r_step  <= '0;
            r_shift <= '0;
            r_ack   <= 1'b1;
            r_bit   <= i2cm_pkg::BIT_DATA;
        end else if (i_accept) begin
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_cmd   <= n_cmd;
            r_step  <= n_step;
            r_shift <= n_shift;
            r_ack   <= n_ack;
            r_bit   <= n_bit;
        end
    end

    a_idle_step_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cmd == i2cm_pkg::OP_TICK) |-> (r_step == '0))
        else $error("idle sequencer holds a nonzero phase step");

    a_reject_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.rejected |-> busy)
        else $error("command rejected while idle");

    a_done_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_result.done_res) |=> (r_cmd == i2cm_pkg::OP_TICK))
        else $error("sequencer still active after done");

    a_load_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !busy && (op != i2cm_pkg::OP_TICK))
        |=> ((r_step == '0) && (r_cmd == $past(op))))
        else $error("command not loaded at phase zero");

endmodule

FILE: rtl/i2cm_out_reg.sv
// ----------------------------------------------------------------------------
// i2cm_out_reg
// Output register with a skid stage between the step logic and the consumer.
// ----------------------------------------------------------------------------
module i2cm_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  i2cm_pkg::t_result    i_result,
    output logic                 o_valid,
    input  logic                 i_stall,
    output i2cm_pkg::t_result    o_result
);

    logic                 r_out_valid;
    logic                 r_skid_valid;
    i2cm_pkg::t_result    r_out;
    i2cm_pkg::t_result    r_skid;
    logic                 accept_in;
    logic                 out_fire;

    assign o_stall   = r_skid_valid;
    assign accept_in = i_valid && !r_skid_valid;
    assign out_fire  = r_out_valid && !i_stall;
    assign o_valid   = r_out_valid;
    assign o_result  = r_out;

    // Track which stages hold a result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (accept_in) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    // Move payloads: skid drains first, otherwise take the new request
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (accept_in) begin
            if (!r_out_valid || out_fire) begin
                r_out <= i_result;
            end else begin
                r_skid <= i_result;
            end
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage full while output stage empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && out_fire) |=> (r_out_valid && !r_skid_valid))
        else $error("skid stage did not drain into output");

    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !out_fire) |=> r_skid_valid)
        else $error("skid stage lost a result");

endmodule

FILE: rtl/i2c_master_bit_sequencer_core.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_core
// Open-drain I2C master bit engine driven by command and tick requests.
// ----------------------------------------------------------------------------
// Every request (a command or a tick) is taken while o_stall is low and yields
// one result, computed by the step logic from the sequencer state and held in
// the output register. Requests may arrive back to back, one per clock, while
// o_stall is low, and a skid stage lets one more request enter while a result waits.
// A command loads a primitive without touching the pins; each following tick
// performs one SCL or SDA write, so bus timing follows the tick rate. Commands
// sent while a primitive is running are flagged as rejected and ignored.
module i2c_master_bit_sequencer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_opcode,
    input  logic [7:0]  i_write_data,
    input  logic        i_sda_sensed,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_scl_out,
    output logic        o_sda_out,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [7:0]  o_read_data,
    output logic        o_ack_level,
    output logic        o_rejected
);

    i2cm_pkg::t_result  step_result;
    i2cm_pkg::t_result  out_result;
    logic               in_accept;

    // Accept a request when the skid stage has room
    assign in_accept = i_valid && !o_stall;

    i2cm_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_opcode     (i_opcode),
        .i_write_data (i_write_data),
        .i_sda_sensed (i_sda_sensed),
        .o_result     (step_result)
    );

    i2cm_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_result (step_result),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (out_result)
    );

    assign o_scl_out   = out_result.scl_out;
    assign o_sda_out   = out_result.sda_out;
    assign o_busy_res  = out_result.busy_res;
    assign o_done_res  = out_result.done_res;
    assign o_read_data = out_result.read_data;
    assign o_ack_level = out_result.ack_level;
    assign o_rejected  = out_result.rejected;

endmodule
